[rtl/valiant_transit_route_select_defines.svh]
// Assertion macros shared by the route select RTL.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef VALIANT_TRANSIT_ROUTE_SELECT_DEFINES_SVH
`define VALIANT_TRANSIT_ROUTE_SELECT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VTRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VTRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vtrs_pkg.sv]
// Types, codes and helper functions for the Valiant transit route select.
// No dependencies; used by every module of the block.
package vtrs_pkg;

  localparam int unsigned ADDR_FIELDS_DEF      = 4;
  localparam int unsigned VALUES_PER_FIELD_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF       = 16;

  localparam int unsigned H_W     = 64;
  localparam int unsigned CYC_W   = 6;
  localparam int unsigned FLD_W   = 16;
  localparam int unsigned NFLD    = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned CIDX_W  = 3;

  localparam logic [H_W-1:0] SEED_MIX  = 64'h9e3779b97f4a7c15;
  localparam logic [31:0]    STEP_MUL  = 32'h85ebca6b;
  localparam int unsigned    STEP_SHIFT = 7;

  localparam logic [1:0] ALG_VALIANT = 2'd1;
  localparam logic [1:0] PH_TRANSIT  = 2'd1;
  localparam logic [1:0] PH_FINAL    = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ROUTE = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_SEED   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_TMASK  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_COUNT0 = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_COUNT1 = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_COUNT2 = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_COUNT3 = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_FSEL,
    ST_MOD,
    ST_RD,
    ST_CHK,
    ST_UPD,
    ST_FINISH
  } state_t;

  function automatic logic [FLD_W-1:0] get_field(input logic [H_W-1:0] addr,
                                                 input logic [1:0] f);
    logic [H_W-1:0] sh;
    sh = addr >> {f, 4'b0000};
    return sh[FLD_W-1:0];
  endfunction

  function automatic logic [H_W-1:0] put_field(input logic [H_W-1:0] addr,
                                               input logic [1:0] f,
                                               input logic [FLD_W-1:0] v);
    logic [H_W-1:0] m;
    m = {{(H_W-FLD_W){1'b0}}, {FLD_W{1'b1}}} << {f, 4'b0000};
    return (addr & ~m) | ({{(H_W-FLD_W){1'b0}}, v} << {f, 4'b0000});
  endfunction

  // Substitute the masked fields that exist in this configuration.
  function automatic logic [H_W-1:0] apply_rw(input logic [H_W-1:0] dst,
                                              input logic [NFLD-1:0] mask,
                                              input logic [H_W-1:0] rw,
                                              input int unsigned nf);
    logic [H_W-1:0] r;
    r = dst;
    for (int f = 0; f < NFLD; f++) begin
      if (mask[f] && f < nf) begin
        r[f*FLD_W +: FLD_W] = rw[f*FLD_W +: FLD_W];
      end
    end
    return r;
  endfunction

  function automatic logic src_matches(input logic [H_W-1:0] src,
                                       input logic [NFLD-1:0] mask,
                                       input logic [H_W-1:0] rw,
                                       input int unsigned nf);
    logic ok;
    ok = 1'b1;
    for (int f = 0; f < NFLD; f++) begin
      if (mask[f]) begin
        if (f >= nf || src[f*FLD_W +: FLD_W] != rw[f*FLD_W +: FLD_W]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  function automatic logic [H_W-1:0] step_term(input logic [1:0] f);
    logic [H_W-1:0] r;
    unique case (f)
      2'd0: r = '0;
      2'd1: r = {32'b0, STEP_MUL};
      2'd2: r = {31'b0, STEP_MUL, 1'b0};
      2'd3: r = {32'b0, STEP_MUL} + {31'b0, STEP_MUL, 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/vtrs_rem.sv]
// Bit-serial remainder of a 64-bit hash by a small list length.
// Depends on vtrs_pkg and the assertion macro header.
`include "valiant_transit_route_select_defines.svh"
module vtrs_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vtrs_pkg::H_W-1:0]    dividend,
  input  logic [vtrs_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [vtrs_pkg::CNT_W-1:0]  rem
);
  import vtrs_pkg::*;

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CYC_W-1:0]  cyc_r, cyc_nxt;
  logic [H_W-1:0]    sh_r, sh_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cyc_nxt  = cyc_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, sh_r[H_W-1]};
    if (start) begin
      run_nxt = 1'b1;
      cyc_nxt = '0;
      sh_nxt  = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      // shift one dividend bit in, subtract when it fits
      sh_nxt  = {sh_r[H_W-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? CNT_W'(trial - {1'b0, divisor})
                                          : CNT_W'(trial);
      cyc_nxt = cyc_r + 1'b1;
      if (cyc_r == '1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cyc_r <= cyc_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  `VTRS_ASSERT_IMP(a_rem_range, done_r && divisor != '0, rem_r < divisor, "rem not below divisor")
  `VTRS_ASSERT_NXT(a_rem_done_pulse, done_r, !done_r, "done held for two cycles")
  `VTRS_ASSERT_IMP(a_rem_done_idle, done_r, !run_r, "done while still running")

endmodule

[rtl/vtrs_table.sv]
// Per-field value lists: one write port, one registered read port.
// Depends on vtrs_pkg for nothing but style; holds the value memory.
module vtrs_table #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned AW     = 6,
  parameter int unsigned DW     = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  import vtrs_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/valiant_transit_route_select.sv]
// Valiant transit route select: top level, sequencer and tag datapath.
// Depends on vtrs_pkg, vtrs_rem, vtrs_table and the assertion macro header.
`include "valiant_transit_route_select_defines.svh"
// A load transaction (command 0) writes one value-list entry at the accepting
// edge and gives no result; busy stays low, so a further transaction may follow
// in the next cycle. A route transaction (command 1) raises busy and gives
// exactly one result, shown for one cycle with out_valid; the receiver cannot
// stall, so sample it then. A packet whose tag is Valiant to-transit with a
// non-empty rewrite mask, or one not injected here, finishes after the tag
// check. An injected packet runs the shift-add seed product, then for every
// transit field with a non-empty list a division in the serial remainder unit,
// a scan of candidates (up to the list length, one memory read each) and a
// hash update; fields skipped only pass through field select. The serial
// remainder unit and the single read port of the value memory set the pace of
// this work. Configuration is always ready; write it only while idle.
module valiant_transit_route_select #(
  parameter int unsigned ADDR_FIELDS      = vtrs_pkg::ADDR_FIELDS_DEF,
  parameter int unsigned VALUES_PER_FIELD = vtrs_pkg::VALUES_PER_FIELD_DEF,
  parameter int unsigned VALUE_BITS       = vtrs_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [63:0]                  in_flow_hash,
  input  logic [63:0]                  in_src_addr,
  input  logic [63:0]                  in_dst_addr,
  input  logic                         in_is_inject,
  input  logic [1:0]                   in_tag_algorithm,
  input  logic [1:0]                   in_tag_phase,
  input  logic [3:0]                   in_tag_rewrite_mask,
  input  logic [63:0]                  in_tag_rewrite_addr,
  input  logic [1:0]                   in_table_field,
  input  logic [3:0]                   in_table_pos,
  input  logic [15:0]                  in_table_value,
  // result channel
  output logic                         out_valid,
  output logic [63:0]                  out_effective_dst,
  output logic                         out_tag_updated,
  output logic [1:0]                   out_algorithm,
  output logic [1:0]                   out_phase,
  output logic                         out_clear_flags,
  output logic [3:0]                   out_rewrite_mask,
  output logic [63:0]                  out_rewrite_addr,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vtrs_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [63:0]                  cfg_data
);
  import vtrs_pkg::*;

  localparam int unsigned DEPTH = ADDR_FIELDS * VALUES_PER_FIELD;
  localparam int unsigned MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [H_W-1:0]   seed_r;
  logic [NFLD-1:0]  tmask_r;
  logic [CNT_W-1:0] cnt_r [NFLD];

  // sequencer
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // latched route transaction
  logic [H_W-1:0]  flow_r, flow_nxt;
  logic [H_W-1:0]  src_r, src_nxt;
  logic [H_W-1:0]  dst_r, dst_nxt;
  logic            inj_r, inj_nxt;
  logic [1:0]      alg_r, alg_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [NFLD-1:0] rmask_r, rmask_nxt;
  logic [H_W-1:0]  raddr_r, raddr_nxt;

  // working registers
  logic [H_W-1:0]   acc_r, acc_nxt;
  logic [H_W-1:0]   ma_r, ma_nxt;
  logic [H_W-1:0]   mb_r, mb_nxt;
  logic [CYC_W-1:0] cyc_r, cyc_nxt;
  logic [H_W-1:0]   h_r, h_nxt;
  logic [2:0]       f_r, f_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [NFLD-1:0]  nmask_r, nmask_nxt;
  logic [H_W-1:0]   naddr_r, naddr_nxt;

  // result registers
  logic [H_W-1:0]  o_dst_r, o_dst_nxt;
  logic            o_upd_r, o_upd_nxt;
  logic [1:0]      o_alg_r, o_alg_nxt;
  logic [1:0]      o_ph_r, o_ph_nxt;
  logic            o_clr_r, o_clr_nxt;
  logic [NFLD-1:0] o_mask_r, o_mask_nxt;
  logic [H_W-1:0]  o_addr_r, o_addr_nxt;

  logic accept, accept_route, load_wr;
  logic transit_case;
  logic fsel_end, fsel_go;
  logic [CNT_W-1:0] n_raw, n_cur;
  logic [FLD_W-1:0] dv, sv, cand;
  logic cand_ok, scan_stop;
  logic [H_W-1:0] acc_sum;

  logic rem_start, rem_done;
  logic [CNT_W-1:0] rem_val;
  logic rd_en;
  logic [MAW-1:0] wr_addr, rd_addr;
  logic [VALUE_BITS-1:0] rd_data;

  assign accept       = start && !busy;
  assign accept_route = accept && (in_command == CMD_ROUTE);
  assign load_wr      = accept && (in_command == CMD_LOAD)
                        && (32'(in_table_field) < ADDR_FIELDS)
                        && (32'(in_table_pos) < VALUES_PER_FIELD);
  assign wr_addr = MAW'(32'(in_table_field) * VALUES_PER_FIELD + 32'(in_table_pos));
  assign rd_addr = MAW'(32'(f_r[1:0]) * VALUES_PER_FIELD + 32'(idx_r));

  assign transit_case = (alg_r == ALG_VALIANT) && (ph_r == PH_TRANSIT) && (rmask_r != '0);

  // list length of the current field, saturated to the list size
  assign n_raw = cnt_r[f_r[1:0]];
  assign n_cur = (32'(n_raw) > VALUES_PER_FIELD) ? CNT_W'(VALUES_PER_FIELD) : n_raw;
  assign fsel_end = (f_r >= 3'(NFLD)) || (32'(f_r) >= ADDR_FIELDS);
  assign fsel_go  = !fsel_end && tmask_r[f_r[1:0]] && (n_cur != '0);

  assign dv   = get_field(dst_r, f_r[1:0]);
  assign sv   = get_field(src_r, f_r[1:0]);
  assign cand = FLD_W'(rd_data);
  assign cand_ok   = (cand != dv) && (cand != sv);
  assign scan_stop = cand_ok || (k_r == n_cur - 1'b1);
  assign acc_sum   = ma_r[0] ? (acc_r + mb_r) : acc_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept_route) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = (transit_case || !inj_r) ? ST_IDLE : ST_MUL;
      ST_MUL:    if (cyc_r == '1) state_nxt = ST_FSEL;
      ST_FSEL: begin
        if (fsel_end) state_nxt = ST_FINISH;
        else if (fsel_go) state_nxt = ST_MOD;
      end
      ST_MOD:    if (rem_done) state_nxt = ST_RD;
      ST_RD:     state_nxt = ST_CHK;
      ST_CHK:    state_nxt = scan_stop ? ST_UPD : ST_RD;
      ST_UPD:    state_nxt = ST_FSEL;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result updates
  always_comb begin
    flow_nxt = flow_r; src_nxt = src_r; dst_nxt = dst_r; inj_nxt = inj_r;
    alg_nxt = alg_r; ph_nxt = ph_r; rmask_nxt = rmask_r; raddr_nxt = raddr_r;
    acc_nxt = acc_r; ma_nxt = ma_r; mb_nxt = mb_r; cyc_nxt = cyc_r;
    h_nxt = h_r; f_nxt = f_r; idx_nxt = idx_r; k_nxt = k_r;
    nmask_nxt = nmask_r; naddr_nxt = naddr_r;
    o_dst_nxt = o_dst_r; o_upd_nxt = o_upd_r; o_alg_nxt = o_alg_r;
    o_ph_nxt = o_ph_r; o_clr_nxt = o_clr_r; o_mask_nxt = o_mask_r;
    o_addr_nxt = o_addr_r;
    out_valid_nxt = 1'b0;
    rem_start = 1'b0;
    rd_en = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_route) begin
          flow_nxt = in_flow_hash; src_nxt = in_src_addr; dst_nxt = in_dst_addr;
          inj_nxt = in_is_inject; alg_nxt = in_tag_algorithm; ph_nxt = in_tag_phase;
          rmask_nxt = in_tag_rewrite_mask; raddr_nxt = in_tag_rewrite_addr;
        end
      end
      ST_CHECK: begin
        // default result repeats the tag
        o_dst_nxt = dst_r; o_upd_nxt = 1'b0; o_alg_nxt = alg_r; o_ph_nxt = ph_r;
        o_clr_nxt = 1'b0; o_mask_nxt = rmask_r; o_addr_nxt = raddr_r;
        if (transit_case) begin
          if (src_matches(src_r, rmask_r, raddr_r, ADDR_FIELDS)) begin
            o_upd_nxt = 1'b1; o_ph_nxt = PH_FINAL; o_clr_nxt = 1'b1;
            o_mask_nxt = '0; o_addr_nxt = '0;
          end else begin
            o_dst_nxt = apply_rw(dst_r, rmask_r, raddr_r, ADDR_FIELDS);
          end
        end
        out_valid_nxt = transit_case || !inj_r;
        acc_nxt = '0; ma_nxt = seed_r; mb_nxt = SEED_MIX; cyc_nxt = '0;
      end
      ST_MUL: begin
        // one partial product of seed times the mixing constant a cycle
        acc_nxt = acc_sum;
        ma_nxt  = ma_r >> 1;
        mb_nxt  = mb_r << 1;
        cyc_nxt = cyc_r + 1'b1;
        if (cyc_r == '1) begin
          h_nxt = (flow_r ^ acc_sum) ^ SEED_MIX;
          f_nxt = '0; nmask_nxt = '0; naddr_nxt = '0;
        end
      end
      ST_FSEL: begin
        if (fsel_go) rem_start = 1'b1;
        else if (!fsel_end) f_nxt = f_r + 1'b1;
      end
      ST_MOD: begin
        if (rem_done) begin
          idx_nxt = rem_val;
          k_nxt   = '0;
        end
      end
      ST_RD: rd_en = 1'b1;
      ST_CHK: begin
        if (scan_stop) begin
          nmask_nxt = nmask_r | (NFLD'(1) << f_r[1:0]);
          naddr_nxt = put_field(naddr_r, f_r[1:0], cand);
        end else begin
          k_nxt   = k_r + 1'b1;
          idx_nxt = (idx_r + 1'b1 == n_cur) ? '0 : idx_r + 1'b1;
        end
      end
      ST_UPD: begin
        h_nxt = h_r ^ ((h_r << STEP_SHIFT) + step_term(f_r[1:0]));
        f_nxt = f_r + 1'b1;
      end
      ST_FINISH: begin
        if (nmask_r != '0) begin
          o_dst_nxt = apply_rw(dst_r, nmask_r, naddr_r, ADDR_FIELDS);
          o_upd_nxt = 1'b1; o_alg_nxt = ALG_VALIANT; o_ph_nxt = PH_TRANSIT;
          o_clr_nxt = 1'b0; o_mask_nxt = nmask_r; o_addr_nxt = naddr_r;
        end
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      tmask_r     <= '0;
      for (int i = 0; i < NFLD; i++) cnt_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SEED:   seed_r   <= cfg_data;
          CFG_TMASK:  tmask_r  <= cfg_data[NFLD-1:0];
          CFG_COUNT0: cnt_r[0] <= cfg_data[CNT_W-1:0];
          CFG_COUNT1: cnt_r[1] <= cfg_data[CNT_W-1:0];
          CFG_COUNT2: cnt_r[2] <= cfg_data[CNT_W-1:0];
          CFG_COUNT3: cnt_r[3] <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    flow_r <= flow_nxt; src_r <= src_nxt; dst_r <= dst_nxt; inj_r <= inj_nxt;
    alg_r <= alg_nxt; ph_r <= ph_nxt; rmask_r <= rmask_nxt; raddr_r <= raddr_nxt;
    acc_r <= acc_nxt; ma_r <= ma_nxt; mb_r <= mb_nxt; cyc_r <= cyc_nxt;
    h_r <= h_nxt; f_r <= f_nxt; idx_r <= idx_nxt; k_r <= k_nxt;
    nmask_r <= nmask_nxt; naddr_r <= naddr_nxt;
    o_dst_r <= o_dst_nxt; o_upd_r <= o_upd_nxt; o_alg_r <= o_alg_nxt;
    o_ph_r <= o_ph_nxt; o_clr_r <= o_clr_nxt; o_mask_r <= o_mask_nxt;
    o_addr_r <= o_addr_nxt;
  end

  vtrs_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (h_r),
    .divisor  (n_cur),
    .done     (rem_done),
    .rem      (rem_val)
  );

  vtrs_table #(
    .DEPTH (DEPTH),
    .AW    (MAW),
    .DW    (VALUE_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (wr_addr),
    .wr_data (in_table_value[VALUE_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_effective_dst = o_dst_r;
  assign out_tag_updated   = o_upd_r;
  assign out_algorithm     = o_alg_r;
  assign out_phase         = o_ph_r;
  assign out_clear_flags   = o_clr_r;
  assign out_rewrite_mask  = o_mask_r;
  assign out_rewrite_addr  = o_addr_r;

  `VTRS_ASSERT_NXT(a_route_busy, accept_route, busy, "route did not raise busy")
  `VTRS_ASSERT_NXT(a_single_strobe, out_valid_r, !out_valid_r, "strobe held two cycles")
  `VTRS_ASSERT_IMP(a_rem_in_mod, rem_done, state_r == ST_MOD, "remainder done outside modulo")

endmodule

[dv/testbench.sv]
// Self-checking testbench for valiant_transit_route_select: predicts each route
// decision and compares it with the block's result. Depends on vtrs_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import vtrs_pkg::*;

  localparam int unsigned NVAL      = 16;
  localparam int unsigned WDOG_MAX  = 4000;
  localparam int unsigned DRAIN_CYC = 600;

  typedef struct packed {
    logic [63:0] eff_dst;
    logic        updated;
    logic [1:0]  alg;
    logic [1:0]  phase;
    logic        clr;
    logic [3:0]  rmask;
    logic [63:0] raddr;
  } route_res_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_command;
  logic [63:0] in_flow_hash, in_src_addr, in_dst_addr, in_tag_rewrite_addr;
  logic in_is_inject;
  logic [1:0] in_tag_algorithm, in_tag_phase, in_table_field;
  logic [3:0] in_tag_rewrite_mask, in_table_pos;
  logic [15:0] in_table_value;
  logic out_valid;
  logic [63:0] out_effective_dst, out_rewrite_addr;
  logic out_tag_updated, out_clear_flags;
  logic [1:0] out_algorithm, out_phase;
  logic [3:0] out_rewrite_mask;
  logic cfg_valid;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  // predictor state
  logic [15:0] value_list [4][NVAL];
  logic [63:0] seed_reg;
  logic [3:0]  tmask_reg;
  logic [4:0]  count_reg [4];
  route_res_t  pending_routes [$];

  int mismatches;
  int idle_cycles;
  bit gaps_on;
  bit failed;

  valiant_transit_route_select uut (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Watchdog: count cycles with no transaction of any kind.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Compare each result with the oldest pending prediction.
  always @(posedge clk) begin
    route_res_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_effective_dst, out_tag_updated, out_algorithm, out_phase,
              out_clear_flags, out_rewrite_mask, out_rewrite_addr};
      if (pending_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        want = pending_routes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: route result exp dst=%h upd=%b alg=%0d ph=%0d clr=%b m=%h a=%h",
                     want.eff_dst, want.updated, want.alg, want.phase, want.clr,
                     want.rmask, want.raddr,
                     " / got dst=%h upd=%b alg=%0d ph=%0d clr=%b m=%h a=%h",
                     got.eff_dst, got.updated, got.alg,
                     got.phase, got.clr, got.rmask, got.raddr);
        end
      end
    end
  end

  function automatic logic [63:0] subst_fields(logic [63:0] d, logic [3:0] m,
                                               logic [63:0] rw);
    for (int f = 0; f < 4; f++)
      if (m[f]) d[f*16 +: 16] = rw[f*16 +: 16];
    return d;
  endfunction

  // Work out the route decision for one packet.
  function automatic route_res_t predict_route(logic [63:0] flow, logic [63:0] src,
      logic [63:0] dst, logic inj, logic [1:0] alg, logic [1:0] ph,
      logic [3:0] rm, logic [63:0] ra);
    route_res_t r;
    logic [63:0] h, naddr;
    logic [3:0] nmask;
    int unsigned n, choice;
    logic [15:0] pick, cand;
    bit hit;
    r = '{dst, 1'b0, alg, ph, 1'b0, rm, ra};
    if (alg == ALG_VALIANT && ph == PH_TRANSIT && rm != 0) begin
      hit = 1;
      for (int f = 0; f < 4; f++)
        if (rm[f] && src[f*16 +: 16] != ra[f*16 +: 16]) hit = 0;
      if (hit) begin
        r.updated = 1; r.phase = PH_FINAL; r.clr = 1; r.rmask = 0; r.raddr = 0;
      end else r.eff_dst = subst_fields(dst, rm, ra);
      return r;
    end
    if (!inj) return r;
    h = (flow ^ (seed_reg * SEED_MIX)) ^ SEED_MIX;
    nmask = 0; naddr = 0;
    for (int f = 0; f < 4; f++) begin
      if (!tmask_reg[f]) continue;
      n = (count_reg[f] > NVAL) ? NVAL : count_reg[f];
      if (n == 0) continue;
      choice = h % n;
      pick = value_list[f][choice];
      if (n > 1)
        for (int k = 0; k < n; k++) begin
          cand = value_list[f][(choice + k) % n];
          pick = cand;
          if (cand != dst[f*16 +: 16] && cand != src[f*16 +: 16]) break;
        end
      nmask[f] = 1;
      naddr[f*16 +: 16] = pick;
      h ^= (h << STEP_SHIFT) + 64'(f) * 64'(STEP_MUL);
    end
    if (nmask == 0) return r;
    return '{subst_fields(dst, nmask, naddr), 1'b1, ALG_VALIANT, PH_TRANSIT,
             1'b0, nmask, naddr};
  endfunction

  // Drop start for a random burst before some transactions.
  task automatic idle_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Send one transaction and hold until it is accepted; start stays high
  // until the next transaction, a gap or a drain replaces it.
  task automatic send_item(logic cmd, logic [63:0] flow, logic [63:0] src,
      logic [63:0] dst, logic inj, logic [1:0] alg, logic [1:0] ph,
      logic [3:0] rm, logic [63:0] ra, logic [1:0] fld, logic [3:0] pos,
      logic [15:0] val);
    idle_gap();
    start <= 1; in_command <= cmd; in_flow_hash <= flow; in_src_addr <= src;
    in_dst_addr <= dst; in_is_inject <= inj; in_tag_algorithm <= alg;
    in_tag_phase <= ph; in_tag_rewrite_mask <= rm; in_tag_rewrite_addr <= ra;
    in_table_field <= fld; in_table_pos <= pos; in_table_value <= val;
    do @(posedge clk); while (busy);
    if (cmd == CMD_LOAD) value_list[fld][pos] = val;
    else pending_routes.insert(pending_routes.size(),
                               predict_route(flow, src, dst, inj, alg, ph, rm, ra));
    @(negedge clk);
  endtask

  task automatic send_route(logic [63:0] flow, logic [63:0] src, logic [63:0] dst,
      logic inj, logic [1:0] alg, logic [1:0] ph, logic [3:0] rm, logic [63:0] ra);
    send_item(CMD_ROUTE, flow, src, dst, inj, alg, ph, rm, ra,
              2'($urandom), 4'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    start <= 0;
    while (pending_routes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SEED:   seed_reg = data;
      CFG_TMASK:  tmask_reg = data[3:0];
      CFG_COUNT0: count_reg[0] = data[4:0];
      CFG_COUNT1: count_reg[1] = data[4:0];
      CFG_COUNT2: count_reg[2] = data[4:0];
      CFG_COUNT3: count_reg[3] = data[4:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_policy(logic [63:0] seed, logic [3:0] tm, int c0, int c1,
                            int c2, int c3);
    wait_drained();
    write_reg(CFG_SEED, seed);
    write_reg(CFG_TMASK, 64'(tm));
    write_reg(CFG_COUNT0, 64'(c0));
    write_reg(CFG_COUNT1, 64'(c1));
    write_reg(CFG_COUNT2, 64'(c2));
    write_reg(CFG_COUNT3, 64'(c3));
    cfg_valid <= 0;
  endtask

  // Fill every list completely so no count ever reads an unwritten entry;
  // ascending distinct values with a random base and stride.
  task automatic fill_lists();
    logic [15:0] base;
    int stride;
    for (int f = 0; f < 4; f++) begin
      base = 16'($urandom_range(0, 3000));
      stride = $urandom_range(1, 3900);
      for (int p = 0; p < NVAL; p++)
        send_item(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 2'(f), 4'(p),
                  16'(base + p * stride));
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick an address whose fields often collide with list entries, so the
  // avoid-source/destination scan and the all-forbidden fallback get hit.
  function automatic logic [63:0] listy_addr();
    logic [63:0] a;
    a = rand64();
    for (int f = 0; f < 4; f++)
      if ($urandom_range(0, 1)) a[f*16 +: 16] = value_list[f][$urandom_range(0, NVAL-1)];
    return a;
  endfunction

  task automatic test_field_extremes();
    send_route(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF, 1, 2'd3, 2'd3, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_route(0, 0, 0, 0, 0, 0, 0, 0);
    send_route(0, 0, 0, 1, 0, 0, 0, 0);
    send_item(CMD_LOAD, rand64(), rand64(), rand64(), 1, 2'd3, 2'd3, 4'hF, rand64(),
              2'd3, 4'd15, 16'hFFFF);
    send_item(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 2'd3, 4'd15, 16'hFFFF);
  endtask

  task automatic test_transit_tag();
    logic [63:0] s;
    s = rand64();
    // source sits on every rewritten field: move to final phase
    send_route(rand64(), s, rand64(), 0, ALG_VALIANT, PH_TRANSIT, 4'hF, s);
    send_route(rand64(), s, rand64(), 1, ALG_VALIANT, PH_TRANSIT, 4'h5,
               {rand64() & 64'hFFFF_0000_FFFF_0000} | (s & 64'h0000_FFFF_0000_FFFF));
    // not there yet: substitute rewrites into destination
    send_route(rand64(), s, rand64(), 1, ALG_VALIANT, PH_TRANSIT, 4'hA, ~s);
    // tags that are not valiant to-transit fall through
    send_route(rand64(), s, rand64(), 0, ALG_VALIANT, PH_FINAL, 4'hF, s);
    send_route(rand64(), s, rand64(), 0, 2'd2, PH_TRANSIT, 4'hF, s);
  endtask

  task automatic test_injection();
    logic [63:0] d;
    fill_lists();
    set_policy(64'h0123_4567_89AB_CDEF, 4'hF, 16, 1, 2, 16);
    send_route(rand64(), listy_addr(), listy_addr(), 1, 0, 0, 0, 0);
    send_route(rand64(), rand64(), rand64(), 1, ALG_VALIANT, PH_TRANSIT, 0, rand64());
    // both candidates of a two-entry list forbidden: fall back to last scanned
    d = rand64();
    d[47:32] = value_list[2][0];
    send_route(rand64(), {rand64()} & ~64'hFFFF_0000_0000 | 64'(value_list[2][1]) << 32,
               d, 1, 0, 0, 0, 0);
    // empty lists and an oversized count
    set_policy(64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 0, 31, 0, 17);
    send_route(rand64(), rand64(), rand64(), 1, 0, 0, 0, 0);
    // all transit fields empty: no rewrite picked
    set_policy(0, 4'h3, 0, 0, 16, 16);
    send_route(rand64(), rand64(), rand64(), 1, 0, 0, 0, 0);
    set_policy(64'h5A5A, 4'h0, 16, 16, 16, 16);
    send_route(rand64(), rand64(), rand64(), 1, 0, 0, 0, 0);
  endtask

  task automatic test_random_routes(int total);
    logic [63:0] s, ra;
    logic [3:0] rm;
    for (int i = 0; i < total; i++) begin
      if (i % 80 == 0)
        set_policy(rand64(), 4'($urandom), $urandom_range(0, 16), $urandom_range(0, 31),
                   $urandom_range(0, 16), $urandom_range(0, 16));
      if (i == total - 60) gaps_on = 0;
      s = listy_addr();
      rm = 4'($urandom);
      case ($urandom_range(0, 9))
        0: send_item(CMD_LOAD, rand64(), rand64(), rand64(), 1'($urandom),
                     2'($urandom), 2'($urandom), rm, rand64(), 2'($urandom),
                     4'($urandom), 16'($urandom));
        1, 2: begin
          ra = ($urandom_range(0, 1)) ? s : rand64();
          send_route(rand64(), s, rand64(), 1'($urandom), ALG_VALIANT, PH_TRANSIT, rm, ra);
        end
        3: send_route(rand64(), s, rand64(), 1'($urandom), 2'($urandom),
                      2'($urandom), rm, rand64());
        default: send_route(rand64(), s, listy_addr(), 1, 2'($urandom), 2'($urandom),
                            rm, rand64());
      endcase
    end
  endtask

  initial begin
    rst_n = 0; start = 0; in_command = 0; in_flow_hash = 0; in_src_addr = 0;
    in_dst_addr = 0; in_is_inject = 0; in_tag_algorithm = 0; in_tag_phase = 0;
    in_tag_rewrite_mask = 0; in_tag_rewrite_addr = 0; in_table_field = 0;
    in_table_pos = 0; in_table_value = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    seed_reg = 0; tmask_reg = 0; count_reg = '{0, 0, 0, 0};
    foreach (value_list[f, p]) value_list[f][p] = 0;
    mismatches = 0; idle_cycles = 0; gaps_on = 1;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_field_extremes();
    test_transit_tag();
    test_injection();
    test_random_routes(320);
    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk);
    failed = (mismatches != 0) || (pending_routes.size() != 0);
    if (!failed) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
